@@ sv/stereo_balance_mixer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo balance mixer
// Concurrent checks on the core clock, off in synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_BALANCE_MIXER_CORE_MACROS_SVH
`define STEREO_BALANCE_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SBM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbm check failed");
// antecedent implies consequent in the next cycle
`define SBM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbm check failed");
`else
`define SBM_ASSERT_SAME(label, ante, cons)
`define SBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/sbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo balance mixer package
// Payload types, register codes and arithmetic constants.
// ----------------------------------------------------------------------------
package sbm_pkg;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_BALANCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_PAN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_PAN        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_MONO      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_MONO       = 3'd4;

   localparam int unsigned PCT_W  = 7;
   localparam int unsigned COEF_W = 10;   // coefficients up to 1000
   localparam int unsigned SUM_W  = 29;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // reset values of the registers
   localparam logic [PCT_W-1:0] RST_STREAM_BALANCE = 7'd50;
   localparam logic [PCT_W-1:0] RST_MAIN_PAN       = 7'd0;
   localparam logic [PCT_W-1:0] RST_SUB_PAN        = 7'd100;

   typedef struct packed {
      logic signed [15:0] main_left;
      logic signed [15:0] main_right;
      logic signed [15:0] sub_left;
      logic signed [15:0] sub_right;
      logic               sub_present;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
   } rsp_type;

   typedef struct packed {
      logic main_mono;
      logic sub_mono;
   } mode_type;

   typedef struct packed {
      logic [COEF_W-1:0] main_left;
      logic [COEF_W-1:0] sub_left;
      logic [COEF_W-1:0] main_right;
      logic [COEF_W-1:0] sub_right;
   } coef_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] left;
      logic signed [SUM_W-1:0] right;
   } sum_type;

endpackage

@@ sv/sbm_coef.sv @@
// ----------------------------------------------------------------------------
// Mixing coefficient unit
// Clamped percent products, then exact /10 by reciprocal, two stages.
// ----------------------------------------------------------------------------
module sbm_coef
   import sbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [PCT_W-1:0] stream_balance,
   input  logic [PCT_W-1:0] main_pan,
   input  logic [PCT_W-1:0] sub_pan,
   output coef_type         coef
);

   localparam int unsigned PROD_W = 14;
   localparam int unsigned WIDE_W = 27;
   // floor(x * 6554 / 2^16) == floor(x / 10) for x up to 10000
   localparam logic [12:0] RECIP_10 = 13'd6554;
   localparam int unsigned RECIP_SH = 16;

   localparam int RST_ML = (PCT_MAX - RST_MAIN_PAN) * (PCT_MAX - RST_STREAM_BALANCE);
   localparam int RST_SL = (PCT_MAX - RST_SUB_PAN) * RST_STREAM_BALANCE;
   localparam int RST_MR = RST_MAIN_PAN * (PCT_MAX - RST_STREAM_BALANCE);
   localparam int RST_SR = RST_SUB_PAN * RST_STREAM_BALANCE;

   logic [PCT_W-1:0]  bal, mp, sp;
   logic [PROD_W-1:0] prod_ml_ff, prod_sl_ff, prod_mr_ff, prod_sr_ff;
   logic [PROD_W-1:0] prod_ml_in, prod_sl_in, prod_mr_in, prod_sr_in;
   coef_type          coef_ff, coef_in;

   function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
      return (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

   function automatic logic [PROD_W-1:0] mul_pct(input logic [PCT_W-1:0] a,
                                                 input logic [PCT_W-1:0] b);
      logic [PROD_W-1:0] ax, bx;
      ax = {{(PROD_W-PCT_W){1'b0}}, a};
      bx = {{(PROD_W-PCT_W){1'b0}}, b};
      return ax * bx;
   endfunction

   function automatic logic [COEF_W-1:0] div10(input logic [PROD_W-1:0] p);
      logic [WIDE_W-1:0] w;
      w = {{(WIDE_W-PROD_W){1'b0}}, p} * {{(WIDE_W-13){1'b0}}, RECIP_10};
      return w[RECIP_SH+COEF_W-1:RECIP_SH];
   endfunction

   always_comb begin
      bal = clamp_pct(stream_balance);
      mp  = clamp_pct(main_pan);
      sp  = clamp_pct(sub_pan);
      prod_ml_in = mul_pct(PCT_MAX - mp, PCT_MAX - bal);
      prod_sl_in = mul_pct(PCT_MAX - sp, bal);
      prod_mr_in = mul_pct(mp, PCT_MAX - bal);
      prod_sr_in = mul_pct(sp, bal);
      coef_in.main_left  = div10(prod_ml_ff);
      coef_in.sub_left   = div10(prod_sl_ff);
      coef_in.main_right = div10(prod_mr_ff);
      coef_in.sub_right  = div10(prod_sr_ff);
   end

   // reset to the values the reset registers give, so no warm-up is needed
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ml_ff <= PROD_W'(RST_ML);
         prod_sl_ff <= PROD_W'(RST_SL);
         prod_mr_ff <= PROD_W'(RST_MR);
         prod_sr_ff <= PROD_W'(RST_SR);
         coef_ff.main_left  <= COEF_W'(RST_ML / 10);
         coef_ff.sub_left   <= COEF_W'(RST_SL / 10);
         coef_ff.main_right <= COEF_W'(RST_MR / 10);
         coef_ff.sub_right  <= COEF_W'(RST_SR / 10);
      end else begin
         prod_ml_ff <= prod_ml_in;
         prod_sl_ff <= prod_sl_in;
         prod_mr_ff <= prod_mr_in;
         prod_sr_ff <= prod_sr_in;
         coef_ff    <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

@@ sv/sbm_mac.sv @@
// ----------------------------------------------------------------------------
// Mixing multiply-accumulate pipeline
// Input register, sub select and mono fold, products, column sums.
// ----------------------------------------------------------------------------
module sbm_mac
   import sbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_item,
   input  mode_type mode,
   input  coef_type coef,
   output logic     out_valid,
   input  logic     out_ready,
   output sum_type  out_sum
);

   localparam int unsigned FOLD_W = 17;
   localparam int unsigned MUL_W  = 28;

   // stage 0: registered input with sub select
   logic               v0_ff;
   logic signed [15:0] ml_ff, mr_ff, sl_ff, sr_ff;
   // stage 1: folded samples
   logic                     v1_ff;
   logic signed [FOLD_W-1:0] fml_ff, fmr_ff, fsl_ff, fsr_ff;
   logic signed [FOLD_W-1:0] fml_in, fmr_in, fsl_in, fsr_in;
   // stage 2: products
   logic                    v2_ff;
   logic signed [MUL_W-1:0] pml_ff, psl_ff, pmr_ff, psr_ff;
   // stage 3: sums
   logic    v3_ff;
   sum_type sum_ff, sum_in;

   logic en0, en1, en2, en3;

   function automatic logic signed [FOLD_W-1:0] fold(input logic mono,
                                                     input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
      logic signed [FOLD_W-1:0] ax, bx;
      ax = {a[15], a};
      bx = {b[15], b};
      return mono ? (ax + bx) : (ax <<< 1);
   endfunction

   function automatic logic signed [MUL_W-1:0] mul(input logic signed [FOLD_W-1:0] s,
                                                   input logic [COEF_W-1:0] k);
      logic signed [MUL_W-1:0] sx, kx;
      sx = {{(MUL_W-FOLD_W){s[FOLD_W-1]}}, s};
      kx = {{(MUL_W-COEF_W){1'b0}}, k};
      return sx * kx;
   endfunction

   // bubbles collapse: a stage moves when it is empty or the next one moves
   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;
   assign in_ready = en0;

   always_comb begin
      fml_in = fold(mode.main_mono, ml_ff, mr_ff);
      fmr_in = fold(mode.main_mono, mr_ff, ml_ff);
      fsl_in = fold(mode.sub_mono, sl_ff, sr_ff);
      fsr_in = fold(mode.sub_mono, sr_ff, sl_ff);
      sum_in.left  = {pml_ff[MUL_W-1], pml_ff} + {psl_ff[MUL_W-1], psl_ff};
      sum_in.right = {pmr_ff[MUL_W-1], pmr_ff} + {psr_ff[MUL_W-1], psr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= in_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         ml_ff <= in_item.main_left;
         mr_ff <= in_item.main_right;
         sl_ff <= in_item.sub_present ? in_item.sub_left  : in_item.main_left;
         sr_ff <= in_item.sub_present ? in_item.sub_right : in_item.main_right;
      end
      if (en1) begin
         fml_ff <= fml_in;
         fmr_ff <= fmr_in;
         fsl_ff <= fsl_in;
         fsr_ff <= fsr_in;
      end
      if (en2) begin
         pml_ff <= mul(fml_ff, coef.main_left);
         psl_ff <= mul(fsl_ff, coef.sub_left);
         pmr_ff <= mul(fmr_ff, coef.main_right);
         psr_ff <= mul(fsr_ff, coef.sub_right);
      end
      if (en3) sum_ff <= sum_in;
   end

   assign out_valid = v3_ff;
   assign out_sum   = sum_ff;

endmodule

@@ sv/sbm_scale.sv @@
// ----------------------------------------------------------------------------
// Output scaling pipeline
// Truncating /2000 by shift and reciprocal, then 16-bit saturation.
// ----------------------------------------------------------------------------
module sbm_scale
   import sbm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  sum_type in_sum,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   localparam int unsigned N_W    = 24;   // magnitude / 16
   localparam int unsigned RCP_W  = 25;
   localparam int unsigned WIDE_W = N_W + RCP_W;
   localparam int unsigned RCP_SH = 31;
   localparam int unsigned Q_W    = 18;
   // floor(n * ceil(2^31/125) / 2^31) == floor(n / 125) for n below 2^24
   localparam logic [RCP_W-1:0] RECIP_125 = 25'd17179870;
   localparam logic [Q_W-1:0]   POS_LIM   = 18'd32767;
   localparam logic [Q_W-1:0]   NEG_LIM   = 18'd32768;

   typedef struct packed {
      logic           neg;
      logic [N_W-1:0] n;
   } mag_type;

   typedef struct packed {
      logic           neg;
      logic [Q_W-1:0] q;
   } quot_type;

   logic     v4_ff, v5_ff, v6_ff;
   mag_type  ml_ff, mr_ff;
   quot_type ql_ff, qr_ff;
   rsp_type  out_ff, out_in;
   logic     en4, en5, en6;

   function automatic mag_type to_mag(input logic signed [SUM_W-1:0] s);
      mag_type          m;
      logic [SUM_W-1:0] a;
      a     = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
      m.neg = s[SUM_W-1];
      m.n   = a[N_W+3:4];
      return m;
   endfunction

   function automatic quot_type to_quot(input mag_type m);
      quot_type          r;
      logic [WIDE_W-1:0] w;
      w     = {{RCP_W{1'b0}}, m.n} * {{N_W{1'b0}}, RECIP_125};
      r.neg = m.neg;
      r.q   = w[RCP_SH+Q_W-1:RCP_SH];
      return r;
   endfunction

   function automatic logic signed [15:0] sat(input quot_type r);
      logic [Q_W-1:0] t;
      if (!r.neg) begin
         t = (r.q > POS_LIM) ? POS_LIM : r.q;
      end else begin
         t = (r.q > NEG_LIM) ? NEG_LIM : r.q;
         t = ~t + Q_W'(1);
      end
      return t[15:0];
   endfunction

   assign en6 = !v6_ff || out_ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign in_ready = en4;

   always_comb begin
      out_in.mix_left  = sat(ql_ff);
      out_in.mix_right = sat(qr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         ml_ff <= to_mag(in_sum.left);
         mr_ff <= to_mag(in_sum.right);
      end
      if (en5) begin
         ql_ff <= to_quot(ml_ff);
         qr_ff <= to_quot(mr_ff);
      end
      if (en6) out_ff <= out_in;
   end

   assign out_valid = v6_ff;
   assign out_item  = out_ff;

endmodule

@@ sv/stereo_balance_mixer_core.sv @@
// ----------------------------------------------------------------------------
// Stereo balance mixer core
// Mixes a main and a sub stereo frame into one saturated stereo frame.
// ----------------------------------------------------------------------------
// One item is accepted every clock while req_stall is low; its result passes
// through an input register, the mono fold, four 17x10 products, the column
// sums, magnitude and shift, the reciprocal multiply that divides by 125, and
// the saturating output register. Each stage holds its own valid bit and
// empty stages are filled while the output is stalled, so req_stall only rises
// once all seven stages hold items and the result at the output is not taken.
// The mixing coefficients are built from the registers in two register
// stages that run ahead of the product stage, so a register write applies to
// every item accepted from the next cycle on. The register port is always
// ready; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`include "stereo_balance_mixer_core_macros.svh"

module stereo_balance_mixer_core
   import sbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // frame input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   // mixed output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PCT_W-1:0]     csr_data
);

   logic [PCT_W-1:0] balance_ff, main_pan_ff, sub_pan_ff;
   mode_type         mode_ff;

   coef_type coef;
   sum_type  mac_sum;
   logic     mac_in_ready;
   logic     mac_valid;
   logic     scale_ready;

   assign csr_ready = 1'b1;

   // register file; only to be written by the user while no item is in flight (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff        <= RST_STREAM_BALANCE;
         main_pan_ff       <= RST_MAIN_PAN;
         sub_pan_ff        <= RST_SUB_PAN;
         mode_ff.main_mono <= 1'b0;
         mode_ff.sub_mono  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STREAM_BALANCE: balance_ff        <= csr_data;
            CSR_MAIN_PAN:       main_pan_ff       <= csr_data;
            CSR_SUB_PAN:        sub_pan_ff        <= csr_data;
            CSR_MAIN_MONO:      mode_ff.main_mono <= csr_data[0];
            CSR_SUB_MONO:       mode_ff.sub_mono  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // coefficient build, clamps percents above 100
   sbm_coef u_coef (
      .clock          (clock),
      .reset          (reset),
      .stream_balance (balance_ff),
      .main_pan       (main_pan_ff),
      .sub_pan        (sub_pan_ff),
      .coef           (coef)
   );

   // stages 0..3: select, fold, multiply, sum
   sbm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (mac_in_ready),
      .in_item   (req_payload),
      .mode      (mode_ff),
      .coef      (coef),
      .out_valid (mac_valid),
      .out_ready (scale_ready),
      .out_sum   (mac_sum)
   );

   // stages 4..6: divide by 2000 (shift, then reciprocal), saturating output register
   sbm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_valid),
      .in_ready  (scale_ready),
      .in_sum    (mac_sum),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_item  (rsp_payload)
   );

   assign req_stall = !mac_in_ready;

   // input only backs up when the whole pipe is full and the output held
   `SBM_ASSERT_SAME(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall && mac_valid)
   // an item at the stage boundary is never dropped while the scaler is busy
   `SBM_ASSERT_NEXT(a_boundary_holds, mac_valid && !scale_ready, mac_valid)
   // left plus right weight of one stream never exceeds full scale
   `SBM_ASSERT_SAME(a_main_bound, 1'b1, {1'b0, coef.main_left} + {1'b0, coef.main_right} <= 11'd1000)
   `SBM_ASSERT_SAME(a_sub_bound, 1'b1, {1'b0, coef.sub_left} + {1'b0, coef.sub_right} <= 11'd1000)

endmodule

@@ dv/stereo_balance_mixer_core_tb.sv @@
// ----------------------------------------------------------------------------
// Stereo balance mixer core testbench
// Streams stereo frames through the mixer under a range of balance, pan and
// mono settings and checks every mixed frame against a behavioural mixer.
// ----------------------------------------------------------------------------
module testbench
   import sbm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CLK_PERIOD     = 2;
   localparam int unsigned RESET_CYCLES   = 9;
   localparam int unsigned PIPE_SLACK     = 12;     // seven stages plus margin
   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned HOLDOFF_CYCLES = 60;
   localparam int unsigned CHUNK_ITEMS    = 100;
   localparam int unsigned CHUNKS         = 19;

   // mixing arithmetic
   localparam longint COEF_SCALE = 10;
   localparam longint MIX_SCALE  = 2000;

   localparam logic signed [15:0] FS_POS = 16'sh7fff;
   localparam logic signed [15:0] FS_NEG = 16'sh8000;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [PCT_W-1:0]     csr_data    = '0;

   // register copy held by the checker
   logic [PCT_W-1:0] cfg_balance;
   logic [PCT_W-1:0] cfg_main_pan;
   logic [PCT_W-1:0] cfg_sub_pan;
   logic             cfg_main_mono;
   logic             cfg_sub_mono;

   req_type     pending_frames [$];   // frames waiting to be offered
   rsp_type     expected_mix [$];     // mixed frames still owed by the core
   logic        req_fired = 1'b0;     // frame taken at the last rising edge
   logic        csr_fired = 1'b0;     // register write taken at the last edge
   logic        rsp_hold  = 1'b0;     // long receiver hold-off
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned rsp_count = 0;

   stereo_balance_mixer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   // ---------------------------------------------------------------------
   // Behavioural mixer
   // ---------------------------------------------------------------------

   // percent registers are 7 bits wide; anything above 100 counts as 100
   function automatic longint pct_limit(input logic [PCT_W-1:0] v);
      return (v > PCT_MAX) ? longint'(PCT_MAX) : longint'(v);
   endfunction

   function automatic logic signed [15:0] clip16(input longint v);
      if (v < longint'(FS_NEG)) v = longint'(FS_NEG);
      if (v > longint'(FS_POS)) v = longint'(FS_POS);
      return 16'(v);
   endfunction

   // One output frame from one input frame under the current registers.
   // Direct paths weigh 2 (stereo) or 1 (mono fold); cross paths 0 or 1.
   // Each coefficient is truncated by the /10 before the fold weight.
   function automatic rsp_type mix_frame(input req_type f);
      longint bal, mpan, span;
      longint fm, gm, fs, gs;
      longint k_ml, k_sl, k_mr, k_sr;
      longint ml, mr, sl, sr, acc_l, acc_r;
      rsp_type o;
      bal  = pct_limit(cfg_balance);
      mpan = pct_limit(cfg_main_pan);
      span = pct_limit(cfg_sub_pan);
      fm   = cfg_main_mono ? 1 : 2;
      gm   = cfg_main_mono ? 1 : 0;
      fs   = cfg_sub_mono ? 1 : 2;
      gs   = cfg_sub_mono ? 1 : 0;
      k_ml = (longint'(PCT_MAX) - mpan) * (longint'(PCT_MAX) - bal) / COEF_SCALE;
      k_sl = (longint'(PCT_MAX) - span) * bal / COEF_SCALE;
      k_mr = mpan * (longint'(PCT_MAX) - bal) / COEF_SCALE;
      k_sr = span * bal / COEF_SCALE;
      ml   = longint'($signed(f.main_left));
      mr   = longint'($signed(f.main_right));
      // with no sub stream the main pair feeds the sub columns
      if (f.sub_present) begin
         sl = longint'($signed(f.sub_left));
         sr = longint'($signed(f.sub_right));
      end else begin
         sl = ml;
         sr = mr;
      end
      acc_l = ml * (fm * k_ml) + mr * (gm * k_ml) + sl * (fs * k_sl) + sr * (gs * k_sl);
      acc_r = ml * (gm * k_mr) + mr * (fm * k_mr) + sl * (gs * k_sr) + sr * (fs * k_sr);
      // SV integer division truncates toward zero, as the core must
      o.mix_left  = clip16(acc_l / MIX_SCALE);
      o.mix_right = clip16(acc_r / MIX_SCALE);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type frame(input logic signed [15:0] ml, mr, sl, sr,
                                     input logic present);
      req_type f;
      f.main_left   = ml;
      f.main_right  = mr;
      f.sub_left    = sl;
      f.sub_right   = sr;
      f.sub_present = present;
      return f;
   endfunction

   // full scale now and then, near-zero values to probe truncation
   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return FS_NEG;
         1:       return FS_POS;
         2:       return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [PCT_W-1:0] random_pct();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return PCT_MAX;
         2:       return PCT_W'($urandom_range(int'(PCT_MAX) + 1, 2**PCT_W - 1));
         default: return PCT_W'($urandom_range(0, int'(PCT_MAX)));
      endcase
   endfunction

   task automatic mismatch_report(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // Writes every index of the register port in turn: the five registers,
   // then the unused indexes with junk, which the core must ignore.
   task automatic load_mix_settings(input logic [PCT_W-1:0] bal, mpan, span,
                                    input logic mmono, smono);
      logic [CSR_IDX_W-1:0] idx;
      @(negedge clock);
      for (int i = 0; i < 2**CSR_IDX_W; i++) begin
         idx = CSR_IDX_W'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_STREAM_BALANCE: csr_data <= bal;
            CSR_MAIN_PAN:       csr_data <= mpan;
            CSR_SUB_PAN:        csr_data <= span;
            CSR_MAIN_MONO:      csr_data <= PCT_W'(mmono);
            CSR_SUB_MONO:       csr_data <= PCT_W'(smono);
            default:            csr_data <= PCT_W'($urandom);
         endcase
         do @(negedge clock); while (!csr_fired);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // sender pause: nothing queued, nothing offered, nothing owed
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_frames.size() != 0 || req_valid || expected_mix.size() != 0);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Frame driver: a new item only once the offered one has been taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_frames.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, random plus the long hold-off
   always @(negedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on each taken frame, checks each taken result,
   // tracks register writes
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fired     <= 1'b0;
         csr_fired     <= 1'b0;
         cfg_balance   <= RST_STREAM_BALANCE;
         cfg_main_pan  <= RST_MAIN_PAN;
         cfg_sub_pan   <= RST_SUB_PAN;
         cfg_main_mono <= 1'b0;
         cfg_sub_mono  <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         csr_fired <= csr_valid && csr_ready;
         if (req_valid && !req_stall)
            expected_mix.insert(expected_mix.size(), mix_frame(req_payload));
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_mix.size() == 0) begin
               mismatch_report($sformatf("result %0d (%0d, %0d) with nothing expected",
                                         rsp_count, rsp_payload.mix_left,
                                         rsp_payload.mix_right));
            end else begin
               want = expected_mix.pop_front();
               if (rsp_payload.mix_left !== want.mix_left)
                  mismatch_report($sformatf("result %0d mix_left %0d, expected %0d",
                                            rsp_count, rsp_payload.mix_left,
                                            want.mix_left));
               if (rsp_payload.mix_right !== want.mix_right)
                  mismatch_report($sformatf("result %0d mix_right %0d, expected %0d",
                                            rsp_count, rsp_payload.mix_right,
                                            want.mix_right));
            end
         end
         // writes to unused indexes leave the registers alone
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STREAM_BALANCE: cfg_balance   <= csr_data;
               CSR_MAIN_PAN:       cfg_main_pan  <= csr_data;
               CSR_SUB_PAN:        cfg_sub_pan   <= csr_data;
               CSR_MAIN_MONO:      cfg_main_mono <= csr_data[0];
               CSR_SUB_MONO:       cfg_sub_mono  <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------------
   initial begin : stimulus
      req_type corner [8];
      corner[0] = frame(FS_POS, FS_POS, FS_POS, FS_POS, 1'b1);
      corner[1] = frame(FS_NEG, FS_NEG, FS_NEG, FS_NEG, 1'b1);
      corner[2] = frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      corner[3] = frame(FS_POS, FS_NEG, FS_NEG, FS_POS, 1'b1);
      corner[4] = frame(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1);
      // sub absent: the sub fields are noise and must not matter
      corner[5] = frame(FS_POS, FS_POS, FS_NEG, FS_NEG, 1'b0);
      corner[6] = frame(FS_NEG, FS_NEG, FS_POS, FS_POS, 1'b0);
      // tiny values: negative products must truncate toward zero
      corner[7] = frame(16'sd1, -16'sd1, 16'sd12345, -16'sd12345, 1'b1);

      send_idle_pct = 24;
      recv_idle_pct = 80;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners under the reset settings
      foreach (corner[i]) pending_frames.insert(pending_frames.size(), corner[i]);
      wait_drained();
      // both streams folded, everything on the left
      load_mix_settings(RST_STREAM_BALANCE, '0, '0, 1'b1, 1'b1);
      foreach (corner[i]) pending_frames.insert(pending_frames.size(), corner[i]);
      wait_drained();
      // all percents above range, only the sub stream folded
      load_mix_settings('1, '1, '1, 1'b0, 1'b1);
      foreach (corner[i]) pending_frames.insert(pending_frames.size(), corner[i]);
      wait_drained();

      // random frames in chunks, new settings between chunks
      for (int unsigned chunk = 0; chunk < CHUNKS; chunk++) begin
         if (chunk < 6) begin
            send_idle_pct = 24;
            recv_idle_pct = 80;
         end else if (chunk < 12) begin
            send_idle_pct = 80;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (chunk)
            0:       load_mix_settings('0, '0, '0, 1'b0, 1'b0);
            1:       load_mix_settings(PCT_MAX, PCT_MAX, PCT_MAX, 1'b1, 1'b1);
            2:       load_mix_settings('0, PCT_MAX, '0, 1'b1, 1'b0);
            default: load_mix_settings(random_pct(), random_pct(), random_pct(),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         // hold the receiver off while frames keep coming, so the pipe
         // fills and the core has to stall its input
         if (chunk == 12) begin
            fork
               begin
                  @(posedge clock);
                  rsp_hold <= 1'b1;
                  repeat (HOLDOFF_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         repeat (CHUNK_ITEMS)
            pending_frames.insert(pending_frames.size(),
                                  frame(random_sample(), random_sample(),
                                        random_sample(), random_sample(),
                                        1'($urandom_range(0, 1))));
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      for (int unsigned n = 0; n < CYCLE_LIMIT; n++) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

endmodule
